// File: rtl/core/fprq_pkg.sv
// Shared types and constants for the feedback priority ready queue.
package fprq_pkg;

  localparam int TASK_W  = 8;
  localparam int PRIO_W  = 4;
  localparam int SLICE_W = 15;
  localparam int BASE_W  = 8;
  // Widest raw slice: base shifted by up to fifteen levels.
  localparam int RAW_W   = BASE_W + 15;

  localparam logic [SLICE_W-1:0] SLICE_MAX      = 15'h7fff;
  localparam logic [BASE_W-1:0]  BASE_SLICE_RST = 8'd8;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } fprq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_FULL     = 2'd2
  } fprq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH,
    S_POP,
    S_POP_DATA
  } fprq_state_t;

  typedef struct packed {
    fprq_cmd_t           cmd;
    logic [TASK_W-1:0]   task_id;
    logic [PRIO_W-1:0]   cur_priority;
    logic [SLICE_W-1:0]  slice_left;
    logic                has_run;
  } fprq_in_t;

  typedef struct packed {
    logic [TASK_W-1:0]   out_task;
    logic [PRIO_W-1:0]   new_priority;
    logic [SLICE_W-1:0]  new_slice;
    logic                is_empty;
    fprq_status_t        status;
  } fprq_out_t;

  // Sequencer -> level store
  typedef struct packed {
    logic                push_en;
    logic                pop_en;
    logic [PRIO_W-1:0]   level;
    logic [TASK_W-1:0]   wr_id;
  } fprq_mem_ctl_t;

  // Level store -> sequencer
  typedef struct packed {
    logic                any_ready;
    logic [PRIO_W-1:0]   top_level;
    logic                level_full;
  } fprq_mem_sts_t;

endpackage

// File: rtl/core/fprq_slice_unit.sv
// Shared slice shifter: level slice, saturated slice and promotion compare.
module fprq_slice_unit import fprq_pkg::*; #(
  parameter int LEVELS
) (
  input  logic [PRIO_W-1:0]  level,
  input  logic [BASE_W-1:0]  base_slice,
  input  logic [SLICE_W-1:0] slice_left,
  output logic [SLICE_W-1:0] slice_clip,
  output logic               promote
);

  logic [PRIO_W-1:0] shamt;
  logic [RAW_W-1:0]  raw;
  logic [RAW_W-1:0]  left_x2;

  assign shamt   = PRIO_W'(LEVELS - 1) - level;
  assign raw     = RAW_W'(base_slice) << shamt;
  assign left_x2 = RAW_W'({slice_left, 1'b0});

  // Compare uses the exact slice, report saturates.
  assign promote    = (raw < left_x2);
  assign slice_clip = (raw > RAW_W'(SLICE_MAX)) ? SLICE_MAX : raw[SLICE_W-1:0];

endmodule

// File: rtl/core/fprq_level_store.sv
// Per-level FIFO storage: id memory, head/tail pointers and fill counts.
module fprq_level_store import fprq_pkg::*; #(
  parameter int LEVELS,
  parameter int QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fprq_mem_ctl_t     ctl,
  output fprq_mem_sts_t     sts,
  output logic [TASK_W-1:0] rd_data
);

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY  = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(ENTRY);
  localparam logic [ADDR_W-1:0] QD_A = ADDR_W'(QUEUE_DEPTH);

  logic [TASK_W-1:0] mem [ENTRY];
  logic [TASK_W-1:0] rd_data_r;

  logic [PTR_W-1:0] head_r [LEVELS];
  logic [PTR_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];

  logic [LVL_W-1:0]  lvl;
  logic [ADDR_W-1:0] lvl_base;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [PTR_W-1:0]  head_adv;
  logic [PTR_W-1:0]  tail_adv;
  logic [PRIO_W-1:0] top_lvl;
  logic              any_ready;

  assign lvl      = ctl.level[LVL_W-1:0];
  assign lvl_base = ADDR_W'(lvl) * QD_A;
  assign wr_addr  = lvl_base + ADDR_W'(tail_r[lvl]);
  assign rd_addr  = lvl_base + ADDR_W'(head_r[lvl]);

  assign head_adv = (head_r[lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r[lvl] + PTR_W'(1);
  assign tail_adv = (tail_r[lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r[lvl] + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.push_en) begin
      mem[wr_addr] <= ctl.wr_id;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (ctl.push_en) begin
      tail_r[lvl] <= tail_adv;
      cnt_r[lvl]  <= cnt_r[lvl] + CNT_W'(1);
    end else if (ctl.pop_en) begin
      head_r[lvl] <= head_adv;
      cnt_r[lvl]  <= cnt_r[lvl] - CNT_W'(1);
    end
  end

  // Highest non-empty level wins
  always_comb begin
    top_lvl   = '0;
    any_ready = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        top_lvl   = PRIO_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  assign sts.any_ready  = any_ready;
  assign sts.top_level  = top_lvl;
  assign sts.level_full = (cnt_r[lvl] == CNT_W'(QUEUE_DEPTH));
  assign rd_data        = rd_data_r;

endmodule

// File: rtl/core/fprq_seq.sv
// Sequencer: steps one transaction through the shared slice unit and the store.
module fprq_seq import fprq_pkg::*; #(
  parameter int LEVELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fprq_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fprq_out_t          out_data,
  output logic [PRIO_W-1:0]  unit_level,
  output logic [SLICE_W-1:0] unit_left,
  input  logic [SLICE_W-1:0] unit_slice,
  input  logic               unit_promote,
  output fprq_mem_ctl_t      mem_ctl,
  input  fprq_mem_sts_t      mem_sts,
  input  logic [TASK_W-1:0]  mem_rd_data
);

  fprq_state_t       state_r, state_nxt;
  fprq_in_t          op_r, op_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              bad_r, bad_nxt;
  logic              empty_r, empty_nxt;
  fprq_out_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              out_free;
  logic              prio_bad;
  logic [PRIO_W-1:0] prio_adj;

  assign out_free = !out_valid_r || !out_stall;
  assign prio_bad = ({1'b0, op_r.cur_priority} >= (PRIO_W + 1)'(LEVELS));

  // Feedback rule: demote on used-up slice, promote on mostly unused slice
  always_comb begin
    prio_adj = op_r.cur_priority;
    if (op_r.slice_left == '0) begin
      if (op_r.has_run && (op_r.cur_priority != '0)) begin
        prio_adj = op_r.cur_priority - PRIO_W'(1);
      end
    end else if (unit_promote && (op_r.cur_priority < PRIO_W'(LEVELS - 1))) begin
      prio_adj = op_r.cur_priority + PRIO_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.cmd == CMD_POP) ? S_POP : S_EVAL;
        end
      end
      S_EVAL:     state_nxt = S_PUSH;
      S_PUSH:     state_nxt = out_free ? S_IDLE : S_PUSH;
      S_POP:      state_nxt = S_POP_DATA;
      S_POP_DATA: state_nxt = out_free ? S_IDLE : S_POP_DATA;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    op_nxt        = op_r;
    prio_nxt      = prio_r;
    bad_nxt       = bad_r;
    empty_nxt     = empty_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unit_level    = prio_r;
    unit_left     = op_r.slice_left;
    mem_ctl       = '{push_en: 1'b0, pop_en: 1'b0, level: prio_r, wr_id: op_r.task_id};
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt = in_data;
        end
      end
      S_EVAL: begin
        unit_level = prio_bad ? '0 : op_r.cur_priority;
        bad_nxt    = prio_bad;
        prio_nxt   = prio_bad ? '0 : prio_adj;
      end
      S_PUSH: begin
        if (out_free) begin
          mem_ctl.push_en       = !bad_r && !mem_sts.level_full;
          out_valid_nxt         = 1'b1;
          out_nxt.out_task      = op_r.task_id;
          out_nxt.is_empty      = 1'b0;
          if (bad_r) begin
            out_nxt.new_priority = '0;
            out_nxt.new_slice    = '0;
            out_nxt.status       = ST_BAD_PRIO;
          end else begin
            out_nxt.new_priority = prio_r;
            out_nxt.new_slice    = unit_slice;
            out_nxt.status       = mem_sts.level_full ? ST_FULL : ST_OK;
          end
        end
      end
      S_POP: begin
        mem_ctl.level  = mem_sts.top_level;
        mem_ctl.pop_en = mem_sts.any_ready;
        prio_nxt       = mem_sts.any_ready ? mem_sts.top_level : '0;
        empty_nxt      = !mem_sts.any_ready;
      end
      S_POP_DATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.status = ST_OK;
          if (empty_r) begin
            out_nxt.out_task     = '0;
            out_nxt.new_priority = '0;
            out_nxt.new_slice    = '0;
            out_nxt.is_empty     = 1'b1;
          end else begin
            out_nxt.out_task     = mem_rd_data;
            out_nxt.new_priority = prio_r;
            out_nxt.new_slice    = unit_slice;
            out_nxt.is_empty     = 1'b0;
          end
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    prio_r  <= prio_nxt;
    bad_r   <= bad_nxt;
    empty_r <= empty_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/feedback_priority_ready_queue.sv
// Top level of the multilevel feedback ready queue.
// A result is registered after the evaluate and push states, or after the pop
// and pop-data states. One transaction, push or pop, is in flight at a time as
// the sequencer steps it through the shared slice shifter and the registered store read.
// A waiting result does not block the next accept; its completion step holds.
// Reset clears pointers, fill counts and the sequencer, base_slice returns to 8;
// the id memory is not cleared.
module feedback_priority_ready_queue import fprq_pkg::*; #(
  parameter int LEVELS      = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fprq_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fprq_out_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [BASE_W-1:0] cfg_wr_data
);

  logic [BASE_W-1:0]  base_slice_r;
  logic [PRIO_W-1:0]  unit_level;
  logic [SLICE_W-1:0] unit_left;
  logic [SLICE_W-1:0] unit_slice;
  logic               unit_promote;
  fprq_mem_ctl_t      mem_ctl;
  fprq_mem_sts_t      mem_sts;
  logic [TASK_W-1:0]  mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_slice_r <= BASE_SLICE_RST;
    end else if (cfg_wr_en) begin
      base_slice_r <= cfg_wr_data;
    end
  end

  fprq_slice_unit #(
    .LEVELS (LEVELS)
  ) u_slice (
    .level      (unit_level),
    .base_slice (base_slice_r),
    .slice_left (unit_left),
    .slice_clip (unit_slice),
    .promote    (unit_promote)
  );

  fprq_level_store #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .sts     (mem_sts),
    .rd_data (mem_rd_data)
  );

  fprq_seq #(
    .LEVELS (LEVELS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .unit_level   (unit_level),
    .unit_left    (unit_left),
    .unit_slice   (unit_slice),
    .unit_promote (unit_promote),
    .mem_ctl      (mem_ctl),
    .mem_sts      (mem_sts),
    .mem_rd_data  (mem_rd_data)
  );

endmodule

// File: rtl/core/fprq_checker.sv
// Port-level checker for the ready queue, bound to the top level.
module fprq_checker import fprq_pkg::*; #(
  parameter int LEVELS
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input fprq_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input fprq_out_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back transactions");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.out_task == '0 && out_data.new_priority == '0 &&
      out_data.new_slice == '0 && out_data.status == ST_OK)
    else $error("empty pop result not cleared");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_BAD_PRIO |->
      {1'b0, out_data.new_priority} < (PRIO_W + 1)'(LEVELS))
    else $error("reported level out of range");

endmodule

bind feedback_priority_ready_queue fprq_checker #(
  .LEVELS (LEVELS)
) u_fprq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/tb_feedback_priority_ready_queue.sv
// Self-checking testbench for the multilevel feedback ready queue.
module tb_feedback_priority_ready_queue import fprq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS      = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200_000;

  // Mirrors the per-level id queues and predicts each reply.
  class ready_queue_mirror;
    logic [BASE_W-1:0] base;
    logic [TASK_W-1:0] level_ids [LEVELS][$];
    fprq_out_t         reply_q [$];
    int unsigned       errors, n_requests, n_checked, n_empty, n_full, n_bad;

    function new();
      base = BASE_SLICE_RST;
      errors = 0;
      n_requests = 0;
      n_checked = 0;
      n_empty = 0;
      n_full = 0;
      n_bad = 0;
    endfunction

    function logic [RAW_W-1:0] level_slice(input int unsigned lvl);
      return RAW_W'(base) << (LEVELS - 1 - lvl);
    endfunction

    function logic [SLICE_W-1:0] clipped_slice(input int unsigned lvl);
      logic [RAW_W-1:0] full;
      full = level_slice(lvl);
      return (full > RAW_W'(SLICE_MAX)) ? SLICE_MAX : full[SLICE_W-1:0];
    endfunction

    function void note_request(input fprq_in_t req);
      fprq_out_t rep;
      int        lvl;
      rep = '0;
      n_requests++;
      if (req.cmd == CMD_PUSH) begin
        rep.out_task = req.task_id;
        if (req.cur_priority >= LEVELS) begin
          rep.status = ST_BAD_PRIO;
          n_bad++;
        end else begin
          lvl = int'(req.cur_priority);
          if (req.slice_left == '0) begin
            if (req.has_run && lvl > 0) lvl--;
          end else if (level_slice(lvl) < (RAW_W'(req.slice_left) << 1)) begin
            // more than half of the slice left unused
            if (lvl < LEVELS - 1) lvl++;
          end
          rep.new_priority = PRIO_W'(lvl);
          rep.new_slice = clipped_slice(lvl);
          if (level_ids[lvl].size() >= QUEUE_DEPTH) begin
            rep.status = ST_FULL;
            n_full++;
          end else begin
            level_ids[lvl].push_back(req.task_id);
          end
        end
      end else begin
        rep.is_empty = 1'b1;
        for (lvl = LEVELS - 1; lvl >= 0 && rep.is_empty; lvl--) begin
          if (level_ids[lvl].size() != 0) begin
            rep.is_empty = 1'b0;
            rep.out_task = level_ids[lvl].pop_front();
            rep.new_priority = PRIO_W'(lvl);
            rep.new_slice = clipped_slice(lvl);
          end
        end
        if (rep.is_empty) n_empty++;
      end
      reply_q.push_back(rep);
    endfunction

    function void cmp_field(input string name, input logic [SLICE_W-1:0] want,
                            input logic [SLICE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(input fprq_out_t got);
      fprq_out_t want;
      if (reply_q.size() == 0) begin
        $error("reply with nothing outstanding: out_task %0d", got.out_task);
        errors++;
      end else begin
        want = reply_q.pop_front();
        n_checked++;
        cmp_field("out_task", SLICE_W'(want.out_task), SLICE_W'(got.out_task));
        cmp_field("new_priority", SLICE_W'(want.new_priority), SLICE_W'(got.new_priority));
        cmp_field("new_slice", want.new_slice, got.new_slice);
        cmp_field("is_empty", SLICE_W'(want.is_empty), SLICE_W'(got.is_empty));
        cmp_field("status", SLICE_W'(want.status), SLICE_W'(got.status));
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  fprq_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  fprq_out_t         out_data;
  logic              cfg_wr_en;
  logic [BASE_W-1:0] cfg_wr_data;

  ready_queue_mirror mirror = new();
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  bit                hold_request = 1'b0;
  int unsigned       n_settings = 0;
  int unsigned       cycles = 0;

  feedback_priority_ready_queue #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Replies that leave this edge are older than requests entering it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) mirror.check_reply(out_data);
      if (in_valid && !in_stall) mirror.note_request(in_data);
    end
  end

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    int unsigned held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        held++;
        if (held >= HOLD_CYCLES) begin
          held = 0;
          hold_request = 1'b0;
        end
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input fprq_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic fprq_in_t push_item(input int unsigned id, input int unsigned prio,
                                         input int unsigned left, input bit ran);
    fprq_in_t t;
    t.cmd = CMD_PUSH;
    t.task_id = TASK_W'(id);
    t.cur_priority = PRIO_W'(prio);
    t.slice_left = SLICE_W'(left);
    t.has_run = ran;
    return t;
  endfunction

  function automatic fprq_in_t rand_item(input int unsigned push_pct,
                                         input int unsigned focus);
    fprq_in_t         t;
    logic [RAW_W-1:0] full;
    int unsigned      pick;
    t.cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
    t.task_id = TASK_W'($urandom_range(255));
    t.has_run = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 6) t.cur_priority = PRIO_W'($urandom_range(15, LEVELS));
    else if (pick < 50) t.cur_priority = PRIO_W'(focus);
    else t.cur_priority = PRIO_W'($urandom_range(LEVELS - 1));
    full = mirror.level_slice(t.cur_priority % LEVELS);
    pick = $urandom_range(99);
    if (pick < 30) t.slice_left = '0;
    // right at the promotion threshold
    else if (pick < 50) t.slice_left = SLICE_W'((full >> 1) + $urandom_range(1));
    else if (pick < 80)
      t.slice_left = SLICE_W'($urandom_range((full > RAW_W'(SLICE_MAX)) ? SLICE_MAX : full));
    else t.slice_left = SLICE_W'($urandom_range(32767));
    return t;
  endfunction

  task automatic run_directed();
    int unsigned i;
    send_item(rand_item(0, 0));                   // pop with every level empty
    send_item(push_item(8'hff, 15, 32767, 1'b1)); // bad priority, top code
    send_item(push_item(8'h00, LEVELS, 0, 1'b0)); // bad priority, first invalid
    send_item(push_item(8'h11, 0, 0, 1'b1));      // slice used up at bottom level
    send_item(push_item(8'h12, 3, 0, 1'b1));      // demote
    send_item(push_item(8'h13, 3, 0, 1'b0));      // used up but never ran
    send_item(push_item(8'h14, 6, 8, 1'b0));      // exactly half left: stays
    send_item(push_item(8'h15, 0, 32640, 1'b1));  // promote from bottom
    // fill the top level, then one more push finds it full
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      if (i % 2 == 0) send_item(push_item(8'h80 + i, LEVELS - 1,
                                          (i == 0) ? 32767 : i + 1, i[1]));
      else send_item(push_item(8'h80 + i, LEVELS - 2, 9 + i, i[1]));
    end
    send_item(push_item(8'h5a, LEVELS - 1, 3, 1'b1));
    send_item(rand_item(0, 0));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sent, burst, push_pct, focus;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 20;
        default: push_pct = 55;
      endcase
      focus = $urandom_range(LEVELS - 1);
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        send_item(rand_item(push_pct, focus));
        sent++;
      end
    end
  endtask

  // Only while idle: sender parked and every reply back.
  task automatic write_base(input logic [BASE_W-1:0] value);
    in_valid <= 1'b0;
    while (mirror.reply_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mirror.base = value;
    n_settings++;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    write_base(8'd255);
    run_random(120);
    hold_request = 1'b1;  // sender keeps offering while replies back up
    run_random(190);

    write_base(8'd1);
    idle_pct = 59;
    run_random(310);

    write_base(BASE_W'($urandom_range(254, 2)));
    idle_pct = 0;
    stall_pct = 59;
    run_random(310);

    write_base(8'd0);   // every slice zero, any leftover promotes
    idle_pct = 7;
    stall_pct = 7;
    run_random(300);

    write_base(BASE_W'($urandom_range(254, 2)));
    idle_pct = 0;
    stall_pct = 0;
    run_random(300);

    write_base(BASE_SLICE_RST);
    idle_pct = 7;
    stall_pct = 7;
    run_random(300);

    in_valid <= 1'b0;
    while (mirror.reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run: %0d transactions in, %0d replies checked, %0d base_slice settings",
             mirror.n_requests, mirror.n_checked, n_settings);
    $display("Seen: %0d empty pops, %0d full-level pushes, %0d bad-priority pushes",
             mirror.n_empty, mirror.n_full, mirror.n_bad);
    if (mirror.errors == 0 && mirror.reply_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
